// ===== rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared codes and types for the first-fit page allocator: commands, block
// status values, result status codes, field widths and config register indices.
// ----------------------------------------------------------------------------
package bfa_pkg;

    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_blk_state;
    typedef logic [1:0] t_res_status;

    localparam t_cmd CMD_ALLOC   = 2'd0;
    localparam t_cmd CMD_FREE    = 2'd1;
    localparam t_cmd CMD_RESERVE = 2'd2;
    localparam t_cmd CMD_SET     = 2'd3;

    localparam t_blk_state BLK_FREE     = 2'd0;
    localparam t_blk_state BLK_UNUSABLE = 2'd1;
    localparam t_blk_state BLK_INUSE    = 2'd2;
    localparam t_blk_state BLK_IGNORE   = 2'd3;

    localparam t_res_status RES_OK       = 2'd0;
    localparam t_res_status RES_NO_RUN   = 2'd1;
    localparam t_res_status RES_NOT_FREE = 2'd2;
    localparam t_res_status RES_RANGE    = 2'd3;

    localparam int ADDR_W  = 48;
    localparam int BYTES_W = 29;
    localparam int COUNT_W = 17;

    localparam logic CFG_BASE   = 1'b0;
    localparam logic CFG_ACTIVE = 1'b1;

endpackage

// ===== rtl/bfa_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bitmap_first_fit_page_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_fit_page_allocator
// First-fit page allocator: block status and run length live in two RAMs,
// walked one block per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// sequence: a divide state shifts address and byte count to blocks, a decode
//   state checks them and picks the walk for alloc, free, reserve or set-block;
//   range errors go straight to the result; one command at a time
// the status RAM port (one block per cycle) sets the walk speed
// reset: synchronous; a clearing pass writes every entry unusable with zero
//   run length before the first command is taken
module bitmap_first_fit_page_allocator #(
    parameter int NUM_BLOCKS  = 65536,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  bfa_pkg::t_cmd       i_cmd,
    input  logic [47:0]         i_address,
    input  logic [28:0]         i_byte_amount,
    input  bfa_pkg::t_blk_state i_new_state,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bfa_pkg::t_res_status o_status,
    output logic [47:0]          o_result_address,
    output logic [16:0]          o_blocks_touched
);
    import bfa_pkg::*;

    localparam int IW  = $clog2(NUM_BLOCKS);
    localparam int CW  = IW + 1;
    localparam int BSH = $clog2(BLOCK_BYTES);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_DEC  = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_RLRD = 4'd6;
    localparam logic [3:0] S_RLWT = 4'd7;
    localparam logic [3:0] S_FREE = 4'd8;
    localparam logic [3:0] S_SRD  = 4'd9;
    localparam logic [3:0] S_SWT  = 4'd10;
    localparam logic [3:0] S_FILL = 4'd11;
    localparam logic [3:0] S_MUL  = 4'd12;
    localparam logic [3:0] S_ADD  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic [3:0]  r_state;
    logic [47:0] r_base;
    logic [16:0] r_active;

    t_cmd        r_cmd;
    t_blk_state  r_ns;
    logic [28:0] r_bytes;
    logic        r_below;

    // offset and block conversion
    logic [47:0]   r_dvd;
    logic [47:0]   r_qa;

    // walker
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_end;
    logic          r_pv;
    logic [IW-1:0] r_pidx;
    logic [IW-1:0] r_blk;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_run;
    logic [IW-1:0] r_start;
    logic [CW-1:0] r_cnt;
    t_blk_state    r_wval;
    logic [16:0]   r_rlval;
    logic          r_to_mul;
    logic [47:0]   r_prod;

    // result
    t_res_status   r_res_st;
    logic [47:0]   r_res_addr;
    logic [CW-1:0] r_res_tch;
    logic          r_ov;
    t_res_status   r_ost;
    logic [47:0]   r_oaddr;
    logic [16:0]   r_otch;

    logic [CW-1:0] w_act;

    logic          st_we;
    logic [IW-1:0] st_waddr;
    t_blk_state    st_wdata;
    t_blk_state    st_rdata;
    logic          rl_we;
    logic [IW-1:0] rl_waddr;
    logic [16:0]   rl_wdata;
    logic [16:0]   rl_rdata;

    logic [48:0]   w_res_end;
    logic [31:0]   w_free_end;
    logic [CW-1:0] w_run_inc;

    assign w_act = ({15'd0, r_active} > 32'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(r_active);

    assign w_res_end  = {1'b0, r_qa} + {1'b0, r_dvd};
    assign w_free_end = 32'(r_blk) + 32'(rl_rdata);
    assign w_run_inc  = r_run + CW'(1);

    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_idx[IW-1:0];
        st_wdata = r_wval;
        rl_we    = 1'b0;
        rl_waddr = r_blk;
        rl_wdata = r_rlval;
        case (r_state)
            S_CLR: begin
                st_we    = 1'b1;
                st_wdata = BLK_UNUSABLE;
                rl_we    = 1'b1;
                rl_waddr = r_idx[IW-1:0];
                rl_wdata = '0;
            end
            S_FILL: begin
                st_we = (r_idx < r_end);
                rl_we = (r_idx == r_end);
            end
            S_FREE: begin
                st_we    = r_pv && (st_rdata != BLK_FREE);
                st_waddr = r_pidx;
                st_wdata = BLK_FREE;
            end
            S_SWT: begin
                st_we    = (r_ns != BLK_IGNORE) && (st_rdata != r_ns);
                st_waddr = r_blk;
                st_wdata = r_ns;
            end
            default: begin
            end
        endcase
    end

    bfa_ram #(.WIDTH(2), .DEPTH(NUM_BLOCKS)) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (st_rdata)
    );

    bfa_ram #(.WIDTH(17), .DEPTH(NUM_BLOCKS)) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (rl_we),
        .i_waddr (rl_waddr),
        .i_wdata (rl_wdata),
        .i_raddr (r_blk),
        .o_rdata (rl_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
            r_base   <= '0;
            r_active <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BASE) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_active <= i_cfg_data[16:0];
                end
            end
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    if (r_idx == CW'(NUM_BLOCKS - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_cmd;
                        r_ns    <= i_new_state;
                        r_bytes <= i_byte_amount;
                        r_below <= (i_address < r_base);
                        r_dvd   <= i_address - r_base;
                        r_res_addr <= '0;
                        r_res_tch  <= '0;
                        r_res_st   <= RES_OK;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // block size is a power of two: divisions are shifts
                    r_qa <= r_dvd >> BSH;
                    if (r_cmd == CMD_ALLOC) begin
                        r_dvd <= (48'(r_bytes) + 48'(BLOCK_BYTES - 1)) >> BSH;
                    end else begin
                        r_dvd <= 48'(r_bytes) >> BSH;
                    end
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (r_cmd == CMD_ALLOC) begin
                        if (r_dvd == '0 || r_dvd > 48'(w_act)) begin
                            r_res_st <= RES_NO_RUN;
                            r_state  <= S_DONE;
                        end else begin
                            r_n     <= CW'(r_dvd);
                            r_idx   <= '0;
                            r_end   <= w_act;
                            r_run   <= '0;
                            r_pv    <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end else if (r_below || r_qa >= 48'(w_act)) begin
                        r_res_st <= RES_RANGE;
                        r_state  <= S_DONE;
                    end else begin
                        r_blk <= r_qa[IW-1:0];
                        r_idx <= CW'(r_qa[IW-1:0]);
                        r_pv  <= 1'b0;
                        case (r_cmd)
                            CMD_FREE: r_state <= S_RLRD;
                            CMD_RESERVE: begin
                                if (w_res_end > 49'(w_act)) begin
                                    r_res_st <= RES_RANGE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_n     <= CW'(r_dvd);
                                    r_end   <= CW'(w_res_end);
                                    r_state <= S_CHK;
                                end
                            end
                            default: r_state <= S_SRD;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_pv   <= (r_idx < r_end);
                    r_pidx <= r_idx[IW-1:0];
                    if (r_idx < r_end) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_pv) begin
                        if (st_rdata == BLK_FREE) begin
                            r_run <= w_run_inc;
                            if (r_run == '0) begin
                                r_start <= r_pidx;
                            end
                            if (w_run_inc == r_n) begin
                                // run complete: mark it in use
                                r_blk     <= (r_run == '0) ? r_pidx : r_start;
                                r_idx     <= CW'((r_run == '0) ? r_pidx : r_start);
                                r_end     <= CW'((r_run == '0) ? r_pidx : r_start) + r_n;
                                r_wval    <= BLK_INUSE;
                                r_rlval   <= 17'(r_n);
                                r_res_tch <= r_n;
                                r_to_mul  <= 1'b1;
                                r_pv      <= 1'b0;
                                r_state   <= S_FILL;
                            end
                        end else begin
                            r_run <= '0;
                        end
                    end else if (r_idx == r_end) begin
                        r_res_st <= RES_NO_RUN;
                        r_state  <= S_DONE;
                    end
                end
                S_CHK: begin
                    r_pv   <= (r_idx < r_end);
                    r_pidx <= r_idx[IW-1:0];
                    if (r_idx < r_end) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_pv) begin
                        if (st_rdata != BLK_FREE) begin
                            r_res_st <= RES_NOT_FREE;
                            r_pv     <= 1'b0;
                            r_state  <= S_DONE;
                        end
                    end else if (r_idx == r_end) begin
                        if (r_ns == BLK_IGNORE) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx    <= CW'(r_blk);
                            r_end    <= (r_ns == BLK_FREE) ? CW'(r_blk) : r_end;
                            r_wval   <= r_ns;
                            r_rlval  <= 17'(r_n);
                            r_res_tch <= (r_ns == BLK_FREE) ? '0 : r_n;
                            r_to_mul <= 1'b0;
                            r_state  <= S_FILL;
                        end
                    end
                end
                S_RLRD: begin
                    r_state <= S_RLWT;
                end
                S_RLWT: begin
                    r_end   <= (w_free_end > 32'(w_act)) ? w_act : CW'(w_free_end);
                    r_cnt   <= '0;
                    r_state <= S_FREE;
                end
                S_FREE: begin
                    r_pv   <= (r_idx < r_end);
                    r_pidx <= r_idx[IW-1:0];
                    if (r_idx < r_end) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_pv) begin
                        if (st_rdata != BLK_FREE) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                    end else if (r_idx == r_end) begin
                        // only the run length entry is left to clear
                        r_rlval   <= '0;
                        r_res_tch <= r_cnt;
                        r_to_mul  <= 1'b0;
                        r_state   <= S_FILL;
                    end
                end
                S_SRD: begin
                    r_state <= S_SWT;
                end
                S_SWT: begin
                    if (r_ns != BLK_IGNORE && st_rdata != r_ns) begin
                        r_res_tch <= CW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_FILL: begin
                    if (r_idx < r_end) begin
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_state <= r_to_mul ? S_MUL : S_DONE;
                    end
                end
                S_MUL: begin
                    r_prod  <= 48'(r_blk) << BSH;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_res_addr <= r_base + r_prod;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || i_out_ready) begin
                        r_ov    <= 1'b1;
                        r_ost   <= r_res_st;
                        r_oaddr <= r_res_addr;
                        r_otch  <= 17'(r_res_tch);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_ov;
    assign o_status         = r_ost;
    assign o_result_address = r_oaddr;
    assign o_blocks_touched = r_otch;

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DIV))
        else $error("accepted beat did not start the divider");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!st_we && !rl_we))
        else $error("memory written while idle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_idx <= r_end))
        else $error("fill ran past its end");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != RES_OK) |-> (o_result_address == '0))
        else $error("failed result carries an address");

    a_free_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE) |-> (r_end <= w_act))
        else $error("free walk past active blocks");

endmodule
